/* hw/rtl/trs_pkg.sv */
// Shared types, constants and command/status structs for the tile residency scanner.
package trs_pkg;

  localparam int GRID  = 5;
  localparam int SLOTS = 32;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WIN_N = GRID * GRID;
  localparam int WIN_W = $clog2(WIN_N + 1);
  localparam int GRID_W = $clog2(GRID + 1);
  localparam int TILE_W = 25;
  localparam int LO_OFF = (GRID - 1) / 2;
  localparam logic [15:0] EXTENT_RESET = 16'd1000;

  localparam logic [1:0] KIND_EVICT = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  typedef struct packed {
    logic start;      // latch camera, start home divide
    logic div_step;   // one quotient bit
    logic calc_home;  // sign-fix quotients into home tile
    logic slot_clr;   // reset slot counter
    logic slot_inc;
    logic evict;      // clear current slot valid
    logic win_clr;    // reset window cursor, best
    logic win_inc;
    logic dist_a;     // product stage for distance
    logic dist_b;     // compare stage
    logic load;       // write best tile into free slot
  } trs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic slot_last;
    logic slot_out;    // current slot valid and outside window
    logic slot_hit;    // some scanned slot valid and equal to window tile
    logic win_last;
    logic found;
    logic have_free;
  } trs_sts_t;

endpackage

/* hw/rtl/trs_datapath.sv */
// Datapath: home divider, slot table, window scan and distance compare.
module trs_datapath import trs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_wdata,
  input  logic signed [31:0]       cam_x,
  input  logic signed [31:0]       cam_z,
  input  trs_cmd_t                 cmd,
  output trs_sts_t                 sts,
  output logic [SLOT_W-1:0]        cur_slot,
  output logic signed [TILE_W-1:0] cur_tx,
  output logic signed [TILE_W-1:0] cur_tz,
  output logic [SLOT_W-1:0]        free_slot,
  output logic signed [TILE_W-1:0] best_tx,
  output logic signed [TILE_W-1:0] best_tz
);

  logic [15:0] extent_r;
  logic [23:0] span_r;               // extent * 256
  logic signed [31:0] cx_r, cz_r;
  logic [31:0] ax_r, az_r;           // dividend magnitude / quotient
  logic [23:0] rx_r, rz_r;           // partial remainders
  logic [5:0]  dcnt_r;
  logic signed [TILE_W-1:0] hx_r, hz_r;
  logic [SLOTS-1:0] valid_r;
  logic signed [TILE_W-1:0] mem_x [SLOTS];
  logic signed [TILE_W-1:0] mem_z [SLOTS];
  logic [SLOT_W:0] scnt_r;
  logic [GRID_W-1:0] wi_r, wj_r;
  logic signed [TILE_W-1:0] wtx, wtz;
  logic signed [49:0] mx, mz;        // window tile origin
  logic signed [27:0] dx_r, dz_r;    // |d| < 3 * span
  logic [55:0] px_r, pz_r;
  logic [56:0] dsum;
  logic [56:0] best_d_r;
  logic found_r, hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) extent_r <= EXTENT_RESET;
    else if (cfg_we) extent_r <= cfg_wdata;
  end

  // Restoring divide, one quotient bit per cycle on both axes.
  logic [24:0] tx_sub, tz_sub;
  always_comb begin
    tx_sub = {rx_r, ax_r[31]} - {1'b0, span_r};
    tz_sub = {rz_r, az_r[31]} - {1'b0, span_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx_r   <= cam_x;
      cz_r   <= cam_z;
      ax_r   <= cam_x[31] ? 32'(-cam_x) : cam_x;
      az_r   <= cam_z[31] ? 32'(-cam_z) : cam_z;
      rx_r   <= '0;
      rz_r   <= '0;
      dcnt_r <= '0;
      span_r <= {((extent_r == 16'd0) ? 16'd1 : extent_r), 8'd0};
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 6'd1;
      if (!tx_sub[24]) begin rx_r <= tx_sub[23:0]; ax_r <= {ax_r[30:0], 1'b1}; end
      else begin rx_r <= {rx_r[22:0], ax_r[31]}; ax_r <= {ax_r[30:0], 1'b0}; end
      if (!tz_sub[24]) begin rz_r <= tz_sub[23:0]; az_r <= {az_r[30:0], 1'b1}; end
      else begin rz_r <= {rz_r[22:0], az_r[31]}; az_r <= {az_r[30:0], 1'b0}; end
    end else if (cmd.calc_home) begin
      hx_r <= cx_r[31] ? TILE_W'(-ax_r) : TILE_W'(ax_r);
      hz_r <= cz_r[31] ? TILE_W'(-az_r) : TILE_W'(az_r);
    end
  end

  // Slot cursor
  always_ff @(posedge clk) begin
    if (cmd.slot_clr) scnt_r <= '0;
    else if (cmd.slot_inc) scnt_r <= scnt_r + 1'b1;
  end
  assign cur_slot = scnt_r[SLOT_W-1:0];

  // Read the slot the cursor leaves; the entry holds while the scan waits.
  always_ff @(posedge clk) begin
    if (cmd.slot_inc) begin
      cur_tx <= mem_x[cur_slot];
      cur_tz <= mem_z[cur_slot];
    end
  end

  // The registered read lags the cursor; latch the slot index alongside it.
  logic [SLOT_W-1:0] rd_slot_r;
  logic              rd_ok_r;
  always_ff @(posedge clk) begin
    rd_slot_r <= cur_slot;
    rd_ok_r   <= cmd.slot_inc;
  end

  logic signed [TILE_W:0] ox, oz;
  always_comb begin
    ox = {cur_tx[TILE_W-1], cur_tx} - {hx_r[TILE_W-1], hx_r};
    oz = {cur_tz[TILE_W-1], cur_tz} - {hz_r[TILE_W-1], hz_r};
  end

  assign wtx = hx_r + TILE_W'(wi_r) - TILE_W'(LO_OFF);
  assign wtz = hz_r + TILE_W'(wj_r) - TILE_W'(LO_OFF);

  always_comb begin
    sts.div_done  = (dcnt_r == 6'd32);
    sts.slot_last = (scnt_r == (SLOT_W+1)'(SLOTS));
    sts.slot_out  = valid_r[rd_slot_r] && rd_ok_r &&
                    ((ox < -(TILE_W+1)'(LO_OFF)) ||
                     (ox > (TILE_W+1)'(GRID - 1 - LO_OFF)) ||
                     (oz < -(TILE_W+1)'(LO_OFF)) ||
                     (oz > (TILE_W+1)'(GRID - 1 - LO_OFF)));
    sts.slot_hit  = hit_r;
    sts.win_last  = (wi_r == GRID_W'(GRID - 1)) && (wj_r == GRID_W'(GRID - 1));
    sts.found     = found_r;
    sts.have_free = ~&valid_r;
  end

  // Lowest free slot: priority encode over the valid bits.
  always_comb begin
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) free_slot = SLOT_W'(s);
    end
  end

  // Residency check for the current window tile accumulates over the slot scan.
  always_ff @(posedge clk) begin
    if (cmd.slot_clr) hit_r <= 1'b0;
    else if (rd_ok_r && valid_r[rd_slot_r] && cur_tx == wtx && cur_tz == wtz)
      hit_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (cmd.evict) valid_r[rd_slot_r] <= 1'b0;
    else if (cmd.load) valid_r[free_slot] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem_x[free_slot] <= best_tx;
      mem_z[free_slot] <= best_tz;
    end
  end

  // Window cursor
  always_ff @(posedge clk) begin
    if (cmd.win_clr) begin
      wi_r <= '0;
      wj_r <= '0;
    end else if (cmd.win_inc) begin
      if (wj_r == GRID_W'(GRID - 1)) begin
        wj_r <= '0;
        wi_r <= wi_r + 1'b1;
      end else begin
        wj_r <= wj_r + 1'b1;
      end
    end
  end

  // Distance: difference stage, then square stage, then compare.
  always_comb begin
    mx = wtx * $signed({1'b0, span_r});
    mz = wtz * $signed({1'b0, span_r});
  end
  always_ff @(posedge clk) begin
    dx_r <= 28'(50'(cx_r) - mx);
    dz_r <= 28'(50'(cz_r) - mz);
  end
  always_ff @(posedge clk) begin
    if (cmd.dist_a) begin
      px_r <= 56'(dx_r * dx_r);
      pz_r <= 56'(dz_r * dz_r);
    end
  end
  assign dsum = {1'b0, px_r} + {1'b0, pz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) found_r <= 1'b0;
    else if (cmd.win_clr) found_r <= 1'b0;
    else if (cmd.dist_b && (!found_r || dsum < best_d_r)) found_r <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (cmd.dist_b && (!found_r || dsum < best_d_r)) begin
      best_d_r <= dsum;
      best_tx  <= wtx;
      best_tz  <= wtz;
    end
  end

endmodule

/* hw/rtl/trs_ctrl.sv */
// Controller: sequences divide, eviction scan, window scan and result output.
module trs_ctrl import trs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [1:0]               o_kind,
  output logic                     o_last,
  output logic                     o_use_cur,
  input  trs_sts_t                 sts,
  output trs_cmd_t                 cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_HOME  = 4'd2;
  localparam logic [3:0] S_EVSCN = 4'd3;
  localparam logic [3:0] S_EVOUT = 4'd4;
  localparam logic [3:0] S_WSCN  = 4'd5;
  localparam logic [3:0] S_WD1   = 4'd6;
  localparam logic [3:0] S_WD2   = 4'd7;
  localparam logic [3:0] S_WD3   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_WPRE  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       hold_r, hold_nxt;   // distance compare pending after the square stage

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_NONE;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      hold_r  <= hold_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EVOUT) || (state_r == S_OUT);
  assign o_kind     = (state_r == S_EVOUT) ? KIND_EVICT : kind_r;
  assign o_last     = (state_r == S_OUT);
  assign o_use_cur  = (state_r == S_EVOUT);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    hold_nxt  = hold_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_HOME;
        else cmd.div_step = 1'b1;
      end
      S_HOME: begin
        cmd.calc_home = 1'b1;
        cmd.slot_clr  = 1'b1;
        state_nxt     = S_EVSCN;
      end
      // One slot read per cycle while no eviction word waits; the check sees the slot read the cycle before.
      S_EVSCN: begin
        if (sts.slot_out) begin
          cmd.evict = 1'b1;
          state_nxt = S_EVOUT;
        end else if (sts.slot_last) begin
          cmd.win_clr = 1'b1;
          state_nxt   = S_WPRE;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_EVOUT: begin
        if (out_tready) begin
          if (sts.slot_last) begin
            cmd.win_clr = 1'b1;
            state_nxt   = S_WPRE;
          end else begin
            cmd.slot_inc = 1'b1;
            state_nxt    = S_EVSCN;
          end
        end
      end
      S_WPRE: begin
        cmd.slot_clr = 1'b1;
        state_nxt    = S_WSCN;
      end
      S_WSCN: begin
        if (sts.slot_last) state_nxt = S_WD1;
        else cmd.slot_inc = 1'b1;
      end
      S_WD1: begin
        if (!sts.slot_hit) state_nxt = S_WD2;  // not resident: on to the square stage
        else state_nxt = S_WD3;
      end
      S_WD2: begin
        if (sts.slot_hit) begin
          state_nxt = S_WD3;
        end else begin
          cmd.dist_a = 1'b1;
          state_nxt  = S_FIN;
          hold_nxt   = 1'b1;
        end
      end
      S_FIN: begin
        if (hold_r) begin
          cmd.dist_b = 1'b1;
          hold_nxt   = 1'b0;
        end
        state_nxt = S_WD3;
      end
      S_WD3: begin
        if (sts.win_last) begin
          if (sts.found && sts.have_free) begin
            cmd.load = 1'b1;
            kind_nxt = KIND_LOAD;
          end else begin
            kind_nxt = KIND_NONE;
          end
          state_nxt = S_OUT;
        end else begin
          cmd.win_inc  = 1'b1;
          cmd.slot_clr = 1'b1;
          state_nxt    = S_WSCN;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("accepting while output pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("output dropped");
  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_OUT) else $error("load outside final step");

endmodule

/* hw/rtl/tile_residency_scanner.sv */
// Top level of the tile residency scanner: controller plus datapath.
//
// Usage: write tile_extent on cfg_we/cfg_wdata while idle (reset value 1000;
// zero acts as one). Each camera word on in_* (x, z in 24.8 fixed point)
// yields zero or more eviction words (kind 0, last 0), one per resident slot
// outside the 5x5 window around the home tile, in slot order, then exactly
// one load (kind 1) or nothing (kind 2) word with tlast high.
// Flow: one camera word at a time. An accept step, the home divide (one
// quotient bit per cycle) and a home step, an eviction scan over the slots
// that pauses for each eviction word, a setup step, then for each of the 25
// window tiles a scan of slot compares plus the distance stages (skipped
// when the tile is resident), then the final word.
// Reset clears all slot valid bits and the controller; the tile table needs
// no clearing pass. When the receiver stalls, the pending word holds on
// out_* and the scan waits; in_tready stays low until the final word leaves.
module tile_residency_scanner import trs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // tile_extent
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // [31:0] camera_x, [63:32] camera_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,    // [4:0] slot, [29:5] tile_x, [54:30] tile_z
  output logic [1:0]  out_tuser,    // [1:0] kind
  output logic        out_tlast
);

  trs_cmd_t cmd;
  trs_sts_t sts;
  logic [SLOT_W-1:0] cur_slot, free_slot, rd_slot;
  logic signed [TILE_W-1:0] cur_tx, cur_tz, best_tx, best_tz;
  logic [1:0] kind;
  logic last, use_cur;
  logic [SLOT_W-1:0] load_slot_r;

  trs_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .o_kind(kind), .o_last(last), .o_use_cur(use_cur), .sts, .cmd
  );

  trs_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .cam_x(in_tdata[31:0]), .cam_z(in_tdata[63:32]),
    .cmd, .sts, .cur_slot, .cur_tx, .cur_tz, .free_slot, .best_tx, .best_tz
  );

  // Evicted slot index is the one read as the cursor moved off it.
  always_ff @(posedge clk) begin
    if (cmd.slot_inc || cmd.slot_clr || cmd.start) rd_slot <= cur_slot;
    if (cmd.load) load_slot_r <= free_slot;
  end

  logic [4:0] slot_o;
  logic signed [TILE_W-1:0] tx_o, tz_o;
  always_comb begin
    if (use_cur) begin
      slot_o = 5'(rd_slot);
      tx_o   = cur_tx;
      tz_o   = cur_tz;
    end else if (kind == KIND_LOAD) begin
      slot_o = 5'(load_slot_r);
      tx_o   = best_tx;
      tz_o   = best_tz;
    end else begin
      slot_o = '0;
      tx_o   = '0;
      tz_o   = '0;
    end
  end

  assign out_tdata = {1'b0, tz_o, tx_o, slot_o};
  assign out_tuser = kind;
  assign out_tlast = last;

endmodule
